>>> hw/rtl/dsdl_pkg.sv
// ----------------------------------------------------------------------------
// dsdl_pkg
// Shared constants and types for the depth sorted draw list builder.
// ----------------------------------------------------------------------------
package dsdl_pkg;

  localparam int MaxDraws  = 64;
  localparam int TaskGroup = 32;
  localparam int AddrW     = $clog2(MaxDraws);
  localparam int CountW    = 7;
  localparam int KeyW      = 50;
  localparam int IdxW      = 16;
  localparam int GrpW      = 12;
  localparam int CoordW    = 24;
  localparam int EntryW    = KeyW + IdxW + GrpW;

  // configuration register indexes
  localparam logic [2:0] REG_EYE_X         = 3'd0;
  localparam logic [2:0] REG_EYE_Y         = 3'd1;
  localparam logic [2:0] REG_EYE_Z         = 3'd2;
  localparam logic [2:0] REG_NEAREST_FIRST = 3'd3;
  localparam logic [2:0] REG_LIST_LIMIT    = 3'd4;
  localparam logic [2:0] REG_ACTIVE_LIMIT  = 3'd5;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [IdxW-1:0] idx;
    logic [GrpW-1:0] grp;
  } entry_t;

  // ceil(m / TaskGroup), saturated to the group field
  function automatic logic [GrpW-1:0] groups_of(input logic [15:0] m);
    logic [16:0] g;
    g = (17'(m) + 17'(TaskGroup - 1)) / 17'(TaskGroup);
    if (g > 17'(4095)) return 12'hFFF;
    return g[GrpW-1:0];
  endfunction

endpackage

>>> hw/rtl/depth_sorted_draw_list_builder.sv
// ----------------------------------------------------------------------------
// depth_sorted_draw_list_builder
// Keeps blended draws sorted by squared eye distance, emits them on the
// last draw of a frame.
// ----------------------------------------------------------------------------
// One draw at a time; the input stalls while a draw is in work. A dropped
// draw holds the input through the key pipeline and a wrap-up state. A kept
// draw first scans the sorted memory from the head for its slot under the
// ordering in force when it arrives, reading and comparing each entry looked
// at, then walks from the tail down to that slot, reading and moving each
// entry, and ends with the final write. A draw that ranks after a full
// memory is dropped after the scan. All of it is bound by the memory's one
// read port. On the last draw each command is read, loaded and shown as a
// beat, which is held while the result side stalls. Memory contents need no
// clearing.
module depth_sorted_draw_list_builder (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         draw_id,
  input  logic signed [23:0]  center_x,
  input  logic signed [23:0]  center_y,
  input  logic signed [23:0]  center_z,
  input  logic                is_blend,
  input  logic                is_resident,
  input  logic [3:0]          level_count,
  input  logic [15:0]         meshlet_total,
  input  logic                final_item,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                has_entry,
  output logic [11:0]         group_count,
  output logic [15:0]         out_draw_id,
  output logic [6:0]          list_count,
  output logic                end_of_list
);
  localparam int AW = dsdl_pkg::AddrW;
  localparam int CW = dsdl_pkg::CountW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_KEY   = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_EMIT  = 4'd4;
  localparam logic [3:0] S_OUT   = 4'd5;
  localparam logic [3:0] S_WAIT  = 4'd6;
  localparam logic [3:0] S_SREAD = 4'd7;
  localparam logic [3:0] S_SCMP  = 4'd8;

  // configuration registers
  logic signed [23:0] eye_x, eye_y, eye_z;
  logic               nearest_first;
  logic [6:0]         list_limit;
  logic [15:0]        active_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      eye_x <= '0; eye_y <= '0; eye_z <= '0;
      nearest_first <= 1'b0;
      list_limit <= 7'd64;
      active_limit <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsdl_pkg::REG_EYE_X:         eye_x <= cfg_data;
        dsdl_pkg::REG_EYE_Y:         eye_y <= cfg_data;
        dsdl_pkg::REG_EYE_Z:         eye_z <= cfg_data;
        dsdl_pkg::REG_NEAREST_FIRST: nearest_first <= cfg_data[0];
        dsdl_pkg::REG_LIST_LIMIT:    list_limit <= cfg_data[6:0];
        dsdl_pkg::REG_ACTIVE_LIMIT:  active_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic signed [23:0] cx, cy, cz;
  logic [15:0]        idx;
  logic [11:0]        grp;
  logic               keep, last, near;
  logic [1:0]         kcnt;
  logic [49:0]        key;

  logic [3:0]    state;
  logic [CW-1:0] kept_count;
  logic [CW-1:0] pos;      // slot being opened during insertion
  logic [CW-1:0] ins;      // insertion slot found by the head scan
  logic [CW-1:0] emit_n;
  logic [CW-1:0] ecnt;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  dsdl_pkg::entry_t     wdata, rdata, new_e;

  dsdl_key u_key (
    .clk(clk), .cx(cx), .cy(cy), .cz(cz),
    .ex(eye_x), .ey(eye_y), .ez(eye_z), .key(key)
  );

  dsdl_store u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic accept;
  logic after;  // new entry ranks after stored rdata
  logic [CW-1:0] lim;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign new_e    = '{key: key, idx: idx, grp: grp};
  assign after    = near ? (rdata.key <= key) : (rdata.key >= key);
  assign lim      = (list_limit > 7'(dsdl_pkg::MaxDraws)) ? 7'(dsdl_pkg::MaxDraws)
                                                          : list_limit;

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = pos[AW-1:0];
    wdata = new_e;
    raddr = AW'(pos - 7'd1);
    if (state == S_SREAD || state == S_SCMP) begin
      raddr = ins[AW-1:0];
    end
    if (state == S_CMP) begin
      we = (pos != 7'(dsdl_pkg::MaxDraws));
      if (pos != ins) begin
        wdata = rdata;
      end
    end
    if (state == S_EMIT || state == S_OUT) begin
      raddr = ecnt[AW-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kept_count <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cx <= center_x; cy <= center_y; cz <= center_z;
            idx  <= draw_id;
            grp  <= dsdl_pkg::groups_of(meshlet_total);
            keep <= is_blend && (draw_id < active_limit) && is_resident &&
                    (level_count != 4'd0) && (meshlet_total != 16'd0);
            last <= final_item;
            near <= nearest_first;
            kcnt <= 2'd0;
            state <= S_KEY;
          end
        end
        S_KEY: begin
          kcnt <= kcnt + 2'd1;
          if (kcnt == 2'd2) begin
            pos <= kept_count;
            ins <= '0;
            if (keep) begin
              state <= S_SREAD;
            end else begin
              state <= S_WAIT;
            end
          end
        end
        S_SREAD: begin
          // read of ins issued; compare next cycle
          state <= S_SCMP;
        end
        S_SCMP: begin
          // advance past entries the new draw ranks after
          if (ins != kept_count && after) begin
            ins <= ins + 7'd1;
            state <= S_SREAD;
          end else if (ins == 7'(dsdl_pkg::MaxDraws)) begin
            state <= S_WAIT;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          // read of pos-1 issued; move it next cycle
          state <= S_CMP;
        end
        S_CMP: begin
          if (pos != ins) begin
            pos <= pos - 7'd1;
            state <= S_READ;
          end else begin
            if (kept_count != 7'(dsdl_pkg::MaxDraws)) begin
              kept_count <= kept_count + 7'd1;
            end
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (last) begin
            emit_n <= (kept_count > lim) ? lim : kept_count;
            ecnt <= '0;
            kept_count <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          // read data for ecnt appears next cycle
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid      <= 1'b1;
            has_entry      <= (emit_n != 7'd0);
            group_count    <= (emit_n != 7'd0) ? rdata.grp : 12'd0;
            out_draw_id    <= (emit_n != 7'd0) ? rdata.idx : 16'd0;
            list_count     <= emit_n;
            end_of_list    <= (emit_n == 7'd0) || (ecnt + 7'd1 == emit_n);
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            if (emit_n == 7'd0 || ecnt + 7'd1 == emit_n) begin
              state <= S_IDLE;
            end else begin
              ecnt <= ecnt + 7'd1;
              state <= S_EMIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a new beat is taken only when idle
  assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_KEY) else $error("item not captured");
  // the store never overfills
  assert property (@(posedge clk) disable iff (rst)
    kept_count <= 7'(dsdl_pkg::MaxDraws)) else $error("kept_count overflow");
  // output shows only during emission
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("stray output");
  // a list never exceeds its limit
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> list_count <= lim) else $error("list too long");
  // the tail walk never passes the insertion slot
  assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> ins <= pos) else $error("walk passed slot");
endmodule

>>> hw/rtl/dsdl_key.sv
// ----------------------------------------------------------------------------
// dsdl_key
// Two stage squared distance: register the squares, then the sum.
// ----------------------------------------------------------------------------
module dsdl_key (
  input  logic                                 clk,
  input  logic signed [dsdl_pkg::CoordW-1:0]   cx,
  input  logic signed [dsdl_pkg::CoordW-1:0]   cy,
  input  logic signed [dsdl_pkg::CoordW-1:0]   cz,
  input  logic signed [dsdl_pkg::CoordW-1:0]   ex,
  input  logic signed [dsdl_pkg::CoordW-1:0]   ey,
  input  logic signed [dsdl_pkg::CoordW-1:0]   ez,
  output logic        [dsdl_pkg::KeyW-1:0]     key
);
  logic signed [24:0] dx, dy, dz;
  logic [24:0] ax, ay, az;
  logic [47:0] sx, sy, sz;

  // absolute differences
  always_comb begin
    dx = 25'(cx) - 25'(ex);
    dy = 25'(cy) - 25'(ey);
    dz = 25'(cz) - 25'(ez);
    ax = dx[24] ? 25'(-dx) : 25'(dx);
    ay = dy[24] ? 25'(-dy) : 25'(dy);
    az = dz[24] ? 25'(-dz) : 25'(dz);
  end

  // square, then sum
  always_ff @(posedge clk) begin
    sx  <= 48'(ax) * 48'(ax);
    sy  <= 48'(ay) * 48'(ay);
    sz  <= 48'(az) * 48'(az);
    key <= 50'(sx) + 50'(sy) + 50'(sz);
  end
endmodule

>>> hw/rtl/dsdl_store.sv
// ----------------------------------------------------------------------------
// dsdl_store
// Sorted entry memory: one synchronous read port, one write port.
// ----------------------------------------------------------------------------
module dsdl_store (
  input  logic                         clk,
  input  logic                         we,
  input  logic [dsdl_pkg::AddrW-1:0]   waddr,
  input  dsdl_pkg::entry_t             wdata,
  input  logic [dsdl_pkg::AddrW-1:0]   raddr,
  output dsdl_pkg::entry_t             rdata
);
  dsdl_pkg::entry_t mem [dsdl_pkg::MaxDraws];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
